### hdl/i2c_master_transaction_sequencer_assert.svh
// assertion macros for the i2c master transaction sequencer checker
// no dependencies; included by the checker file only
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH

// property checked at every edge outside reset
`define I2CMTS_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("i2cmts assertion failed");

// property checked at every edge, reset included
`define I2CMTS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("i2cmts assertion failed");

`endif

### hdl/i2cmts_pkg.sv
// types and constants of the i2c master transaction sequencer
// no dependencies; imported by the top level and the checker
package i2cmts_pkg;

    // bus commands towards the byte-level engine
    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_START  = 3'd1,
        CMD_SEND   = 3'd2,
        CMD_RXACK  = 3'd3,
        CMD_RXNACK = 3'd4,
        CMD_STOP   = 3'd5
    } t_bus_cmd;

    // transaction phases, named after the command waiting for completion
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_ADDRW  = 4'd2,
        PH_DATAW  = 4'd3,
        PH_REGW   = 4'd4,
        PH_RSTART = 4'd5,
        PH_ADDRR  = 4'd6,
        PH_RXACK  = 4'd7,
        PH_RXNACK = 4'd8
    } t_phase;

    // item function codes
    localparam logic FUNC_REQUEST  = 1'b0;
    localparam logic FUNC_COMPLETE = 1'b1;

    // transaction modes
    localparam logic [1:0] MODE_READ     = 2'd0;
    localparam logic [1:0] MODE_WRITE    = 2'd1;
    localparam logic [1:0] MODE_COMBINED = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    // engine status codes, upper five bits significant
    localparam logic [7:0] STATUS_MASK   = 8'hF8;
    localparam logic [7:0] STATUS_START  = 8'h08;
    localparam logic [7:0] STATUS_RSTART = 8'h10;
    localparam logic [7:0] STATUS_ADDRW  = 8'h18;
    localparam logic [7:0] STATUS_DATAW  = 8'h28;
    localparam logic [7:0] STATUS_ADDRR  = 8'h40;
    localparam logic [7:0] STATUS_DATAR  = 8'h50;
    localparam logic [7:0] STATUS_DATARN = 8'h58;

    typedef struct packed {
        logic       func;
        logic [1:0] mode;
        logic [6:0] slave_address;
        logic [7:0] byte_count;
        logic [7:0] tx_byte;
        logic [7:0] bus_status;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_bus_cmd   bus_command;
        logic [7:0] send_byte;
        logic       read_valid;
        logic [7:0] read_data;
        logic       done_res;
        logic       failed;
    } t_out_item;

endpackage

### hdl/i2c_master_transaction_sequencer.sv
// i2c master transaction sequencer, top level
// depends on i2cmts_pkg
//
// Sits above a byte-level i2c bus engine and decides, one item at a time, the
// next command that engine must run. A request item (func 0) opens a read, a
// write, or a combined transaction (one register byte written, repeated start,
// then reads); the block answers with a start command. Every completion item
// (func 1) carries the engine's status and any received byte; the block checks
// the status against what the pending command should have produced and answers
// with the next command (send address or data, repeated start, receive with
// ack, receive with nack on the last byte, or stop), passing on received bytes
// with read_valid. Write data bytes are taken from tx_byte of the completion
// item at which the next data byte falls due. Any unexpected status ends the
// transaction with a stop flagged done_res and failed. A read count of zero
// reads one byte; a write count of zero sends only the address. Requests while
// busy, completions while idle and the reserved mode all give an all-zero
// result. Exactly one result comes out per item. Throughput is one item per
// clock while o_in_stall is low: the whole decision is one level of phase logic
// between the input handshake and the output register. A one-entry skid stage
// behind the output register keeps input acceptance independent of i_out_stall
// until the skid fills; o_in_stall rises only while that skid is full.
module i2c_master_transaction_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  i2cmts_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output i2cmts_pkg::t_out_item o_out_item
);
    import i2cmts_pkg::*;

    // transaction state
    t_phase     r_phase, n_phase;
    logic [1:0] r_active_mode, n_active_mode;
    logic [6:0] r_target_address, n_target_address;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_held_reg, n_held_reg;

    // output register and skid stage
    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;

    logic      in_fire;
    logic      out_take;
    t_out_item res;
    logic [7:0] status;
    logic [7:0] expect_status;
    logic [7:0] rx_left;   // bytes left once the byte just received is counted

    assign o_in_stall  = r_skid_valid;
    assign in_fire     = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign status  = i_in_item.bus_status & STATUS_MASK;
    assign rx_left = (r_bytes_left != 8'd0) ? r_bytes_left - 8'd1 : 8'd0;

    // status the pending command should produce
    always_comb begin
        unique case (r_phase)
            PH_START:  expect_status = STATUS_START;
            PH_ADDRW:  expect_status = STATUS_ADDRW;
            PH_DATAW:  expect_status = STATUS_DATAW;
            PH_REGW:   expect_status = STATUS_DATAW;
            PH_RSTART: expect_status = STATUS_RSTART;
            PH_ADDRR:  expect_status = STATUS_ADDRR;
            PH_RXACK:  expect_status = STATUS_DATAR;
            PH_RXNACK: expect_status = STATUS_DATARN;
            default:   expect_status = 8'd0;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_active_mode    <= MODE_READ;
            r_target_address <= '0;
            r_bytes_left     <= '0;
            r_held_reg       <= '0;
        end else begin
            r_phase          <= n_phase;
            r_active_mode    <= n_active_mode;
            r_target_address <= n_target_address;
            r_bytes_left     <= n_bytes_left;
            r_held_reg       <= n_held_reg;
        end
    end

    // next phase and result of the accepted item
    always_comb begin
        n_phase          = r_phase;
        n_active_mode    = r_active_mode;
        n_target_address = r_target_address;
        n_bytes_left     = r_bytes_left;
        n_held_reg       = r_held_reg;
        res              = '0;
        res.bus_command  = CMD_NONE;

        if (in_fire) begin
            if (i_in_item.func == FUNC_REQUEST) begin
                // requests only open a transaction from idle with a known mode
                if (r_phase == PH_IDLE && i_in_item.mode != MODE_RESERVED) begin
                    n_active_mode    = i_in_item.mode;
                    n_target_address = i_in_item.slave_address;
                    n_held_reg       = i_in_item.tx_byte;
                    // a read of zero bytes still reads one
                    if (i_in_item.mode != MODE_WRITE && i_in_item.byte_count == 8'd0) begin
                        n_bytes_left = 8'd1;
                    end else begin
                        n_bytes_left = i_in_item.byte_count;
                    end
                    n_phase         = PH_START;
                    res.bus_command = CMD_START;
                end
            end else if (r_phase == PH_IDLE) begin
                // stray completion: nothing to do
                n_phase = PH_IDLE;
            end else if (status != expect_status) begin
                // unexpected status aborts with stop, received byte dropped
                n_phase         = PH_IDLE;
                res.bus_command = CMD_STOP;
                res.done_res    = 1'b1;
                res.failed      = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_START: begin
                        res.bus_command = CMD_SEND;
                        if (r_active_mode == MODE_READ) begin
                            n_phase       = PH_ADDRR;
                            res.send_byte = {r_target_address, 1'b1};
                        end else begin
                            n_phase       = PH_ADDRW;
                            res.send_byte = {r_target_address, 1'b0};
                        end
                    end
                    PH_ADDRW: begin
                        if (r_active_mode == MODE_COMBINED) begin
                            n_phase         = PH_REGW;
                            res.bus_command = CMD_SEND;
                            res.send_byte   = r_held_reg;
                        end else if (r_bytes_left != 8'd0) begin
                            n_bytes_left    = r_bytes_left - 8'd1;
                            n_phase         = PH_DATAW;
                            res.bus_command = CMD_SEND;
                            res.send_byte   = i_in_item.tx_byte;
                        end else begin
                            n_phase         = PH_IDLE;
                            res.bus_command = CMD_STOP;
                            res.done_res    = 1'b1;
                        end
                    end
                    PH_DATAW: begin
                        if (r_bytes_left != 8'd0) begin
                            n_bytes_left    = r_bytes_left - 8'd1;
                            res.bus_command = CMD_SEND;
                            res.send_byte   = i_in_item.tx_byte;
                        end else begin
                            n_phase         = PH_IDLE;
                            res.bus_command = CMD_STOP;
                            res.done_res    = 1'b1;
                        end
                    end
                    PH_REGW: begin
                        n_phase         = PH_RSTART;
                        res.bus_command = CMD_START;
                    end
                    PH_RSTART: begin
                        n_phase         = PH_ADDRR;
                        res.bus_command = CMD_SEND;
                        res.send_byte   = {r_target_address, 1'b1};
                    end
                    PH_ADDRR: begin
                        // last byte gets nack
                        if (r_bytes_left > 8'd1) begin
                            n_phase         = PH_RXACK;
                            res.bus_command = CMD_RXACK;
                        end else begin
                            n_phase         = PH_RXNACK;
                            res.bus_command = CMD_RXNACK;
                        end
                    end
                    PH_RXACK: begin
                        n_bytes_left   = rx_left;
                        res.read_valid = 1'b1;
                        res.read_data  = i_in_item.rx_byte;
                        if (rx_left > 8'd1) begin
                            n_phase         = PH_RXACK;
                            res.bus_command = CMD_RXACK;
                        end else begin
                            n_phase         = PH_RXNACK;
                            res.bus_command = CMD_RXNACK;
                        end
                    end
                    PH_RXNACK: begin
                        n_bytes_left    = 8'd0;
                        n_phase         = PH_IDLE;
                        res.bus_command = CMD_STOP;
                        res.read_valid  = 1'b1;
                        res.read_data   = i_in_item.rx_byte;
                        res.done_res    = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // output register and skid occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // skid drains into the output register when it frees up
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payloads
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

endmodule

### hdl/i2cmts_checker.sv
// port-level checker for the i2c master transaction sequencer, with its bind
// depends on i2cmts_pkg and i2c_master_transaction_sequencer_assert.svh
`include "i2c_master_transaction_sequencer_assert.svh"

module i2cmts_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input i2cmts_pkg::t_out_item o_out_item
);
    import i2cmts_pkg::*;

    // no result survives reset
    `I2CMTS_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid)

    // a stalled result stays put
    `I2CMTS_ASSERT_RST(a_stall_holds, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))

    // an accepted item always leaves a result waiting on the next cycle
    `I2CMTS_ASSERT_RST(a_accept_to_result, i_clk, i_rst_n,
        i_in_valid && !o_in_stall |=> o_out_valid)

    // a failure or a finished transaction always ends with a stop flagged done_res
    `I2CMTS_ASSERT_RST(a_fail_is_stop, i_clk, i_rst_n,
        o_out_valid && (o_out_item.failed || o_out_item.done_res)
        |-> o_out_item.bus_command == CMD_STOP && o_out_item.done_res)

    // received bytes come only with a receive or a clean stop
    `I2CMTS_ASSERT_RST(a_read_with_rx, i_clk, i_rst_n,
        o_out_valid && o_out_item.read_valid
        |-> !o_out_item.failed && (o_out_item.bus_command == CMD_RXACK
            || o_out_item.bus_command == CMD_RXNACK
            || o_out_item.bus_command == CMD_STOP))

endmodule

bind i2c_master_transaction_sequencer i2cmts_checker u_i2cmts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
